[rtl/fnlt_pkg.sv]
// ----------------------------------------------------------------------------
// fnlt_pkg: shared definitions for the filtered-noise LED twinkle block
// Constants, register codes, coefficient and history records, and the
// control records passed between the pipeline and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fnlt_pkg;

	// Number of LEDs and the address width of the per-LED history store.
	localparam int LED_TOTAL = 512;
	localparam int LED_AW    = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;

	// Field widths of the stream words and the configuration channel.
	localparam int IDX_W       = 9;
	localparam int BRIGHT_W    = 8;
	localparam int LEVEL_W     = 32;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 17;

	// Noise generator constants.
	localparam logic [31:0] LCG_MUL = 32'd214013;
	localparam logic [31:0] LCG_ADD = 32'd2531011;

	// Division by 4096 is a shift by this amount.
	localparam int DIV_SHIFT = 12;

	localparam logic [BRIGHT_W-1:0] BRIGHT_ON  = 8'd255;
	localparam logic [BRIGHT_W-1:0] BRIGHT_OFF = 8'd0;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0  = 3'd0,
		REG_B1  = 3'd1,
		REG_B2  = 3'd2,
		REG_B3  = 3'd3,
		REG_A1  = 3'd4,
		REG_A2  = 3'd5,
		REG_A3  = 3'd6,
		REG_THR = 3'd7
	} cfg_reg_t;

	// Register reset values.
	localparam logic signed [11:0] B0_RST  = 12'sd204;
	localparam logic signed [11:0] B1_RST  = -12'sd393;
	localparam logic signed [11:0] B2_RST  = 12'sd207;
	localparam logic signed [11:0] B3_RST  = -12'sd18;
	localparam logic signed [14:0] A1_RST  = -15'sd10219;
	localparam logic signed [14:0] A2_RST  = 15'sd8263;
	localparam logic signed [14:0] A3_RST  = -15'sd2139;
	localparam logic signed [16:0] THR_RST = -17'sd1000;

	// Filter weights and lighting threshold.
	typedef struct packed {
		logic signed [11:0] b0;
		logic signed [11:0] b1;
		logic signed [11:0] b2;
		logic signed [11:0] b3;
		logic signed [14:0] a1;
		logic signed [14:0] a2;
		logic signed [14:0] a3;
		logic signed [16:0] thr;
	} coef_t;

	// One LED's history: three past samples and three past outputs, newest first.
	typedef struct packed {
		logic [15:0] x0;
		logic [15:0] x1;
		logic [15:0] x2;
		logic [31:0] y0;
		logic [31:0] y1;
		logic [31:0] y2;
	} hist_t;

	localparam int HIST_W = $bits(hist_t);

	// History write-back from the filter pipeline.
	typedef struct packed {
		logic              en;
		logic [LED_AW-1:0] addr;
		hist_t             data;
	} wb_t;

	// Pipeline occupancy, used for input flow control and the same-LED interlock.
	typedef struct packed {
		logic             s1_free;
		logic             s1_v;
		logic [IDX_W-1:0] s1_led;
		logic             s2_v;
		logic [IDX_W-1:0] s2_led;
	} pipe_stat_t;

endpackage

`default_nettype wire

[rtl/fnlt_ram.sv]
// ----------------------------------------------------------------------------
// fnlt_ram: generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fnlt_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/fnlt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// fnlt_cfg_regs: configuration register file
// Holds the filter weights and the lighting threshold; each write keeps
// only the low bits that fit the register.
// ----------------------------------------------------------------------------
`default_nettype none

module fnlt_cfg_regs
	import fnlt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output coef_t                      coef
);

	coef_t coef_q;

	// The register file takes a word in every cycle.
	assign cfg_ready = 1'b1;
	assign coef      = coef_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0  <= B0_RST;
			coef_q.b1  <= B1_RST;
			coef_q.b2  <= B2_RST;
			coef_q.b3  <= B3_RST;
			coef_q.a1  <= A1_RST;
			coef_q.a2  <= A2_RST;
			coef_q.a3  <= A3_RST;
			coef_q.thr <= THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_B0:  coef_q.b0  <= cfg_data[11:0];
				REG_B1:  coef_q.b1  <= cfg_data[11:0];
				REG_B2:  coef_q.b2  <= cfg_data[11:0];
				REG_B3:  coef_q.b3  <= cfg_data[11:0];
				REG_A1:  coef_q.a1  <= cfg_data[14:0];
				REG_A2:  coef_q.a2  <= cfg_data[14:0];
				REG_A3:  coef_q.a3  <= cfg_data[14:0];
				REG_THR: coef_q.thr <= cfg_data[16:0];
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/fnlt_lcg.sv]
// ----------------------------------------------------------------------------
// fnlt_lcg: shared noise generator
// A 32-bit linear congruential generator; the upper half of the next
// state is the noise sample for the LED being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module fnlt_lcg
	import fnlt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	output logic      [15:0] sample
);

	logic [31:0] state_q;
	logic [31:0] state_next;

	// Next state modulo 2^32.
	assign state_next = state_q * LCG_MUL + LCG_ADD;
	assign sample     = state_next[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_next;
		end
	end

endmodule

`default_nettype wire

[rtl/fnlt_filter.sv]
// ----------------------------------------------------------------------------
// fnlt_filter: third-order IIR filter pipeline
// Stage 1 holds the LED, its noise sample and its history; stage 2 holds
// the seven weighted products; the output register holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module fnlt_filter
	import fnlt_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic [IDX_W-1:0]    ld_led,
	input  wire logic                ld_in_range,
	input  wire logic [15:0]         ld_sample,
	input  wire hist_t               rd_hist,
	input  wire coef_t               coef,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic      [IDX_W-1:0]    out_led,
	output logic      [BRIGHT_W-1:0] out_bright,
	output logic      [LEVEL_W-1:0]  out_level,
	output wb_t                      wb,
	output pipe_stat_t               stat
);

	// Stage 1 registers (history comes straight from the RAM read register).
	logic             s1_v_q;
	logic [IDX_W-1:0] led_s1;
	logic             in_range_s1;
	logic [15:0]      sample_s1;

	// Stage 2 registers.
	logic             s2_v_q;
	logic [IDX_W-1:0] led_s2;
	logic             in_range_s2;
	logic [15:0]      sample_s2;
	logic [15:0]      x0_s2;
	logic [15:0]      x1_s2;
	logic [31:0]      y0_s2;
	logic [31:0]      y1_s2;
	logic [31:0]      pb0_s2;
	logic [31:0]      pb1_s2;
	logic [31:0]      pb2_s2;
	logic [31:0]      pb3_s2;
	logic [31:0]      pa1_s2;
	logic [31:0]      pa2_s2;
	logic [31:0]      pa3_s2;

	// Output register.
	logic                out_v_q;
	logic [IDX_W-1:0]    out_led_q;
	logic [BRIGHT_W-1:0] out_bright_q;
	logic [LEVEL_W-1:0]  out_level_q;

	logic s1_adv;
	logic s2_adv;

	logic signed [28:0] mul_b0;
	logic signed [28:0] mul_b1;
	logic signed [28:0] mul_b2;
	logic signed [28:0] mul_b3;
	logic signed [46:0] mul_a1;
	logic signed [46:0] mul_a2;
	logic signed [46:0] mul_a3;

	logic [31:0]        acc;
	logic [31:0]        acc_adj;
	logic signed [31:0] y_new;
	logic signed [31:0] thr_ext;
	logic               lit;

	// Stage advance: each stage moves when the one after it is empty or moving.
	assign s2_adv = s2_v_q && (!out_v_q || out_ready);
	assign s1_adv = s1_v_q && (!s2_v_q || s2_adv);

	assign stat.s1_free = !s1_v_q || s1_adv;
	assign stat.s1_v    = s1_v_q;
	assign stat.s1_led  = led_s1;
	assign stat.s2_v    = s2_v_q;
	assign stat.s2_led  = led_s2;

	// Weighted products; only the low 32 bits of each are kept.
	always_comb begin
		mul_b0 = $signed(coef.b0) * $signed({1'b0, sample_s1});
		mul_b1 = $signed(coef.b1) * $signed({1'b0, rd_hist.x0});
		mul_b2 = $signed(coef.b2) * $signed({1'b0, rd_hist.x1});
		mul_b3 = $signed(coef.b3) * $signed({1'b0, rd_hist.x2});
		mul_a1 = $signed(coef.a1) * $signed(rd_hist.y0);
		mul_a2 = $signed(coef.a2) * $signed(rd_hist.y1);
		mul_a3 = $signed(coef.a3) * $signed(rd_hist.y2);
	end

	// Wrapping sum, division by 4096 toward zero, threshold compare.
	always_comb begin
		acc     = pb0_s2 + pb1_s2 + pb2_s2 + pb3_s2 - pa1_s2 - pa2_s2 - pa3_s2;
		acc_adj = acc + (acc[31] ? ((32'd1 << DIV_SHIFT) - 32'd1) : 32'd0);
		y_new   = $signed(acc_adj) >>> DIV_SHIFT;
		thr_ext = {{(32 - $bits(coef.thr)){coef.thr[$bits(coef.thr) - 1]}}, coef.thr};
		lit     = y_new < thr_ext;
	end

	// History write-back as the item leaves stage 2.
	assign wb.en      = s2_adv && in_range_s2;
	assign wb.addr    = LED_AW'(led_s2);
	assign wb.data.x0 = sample_s2;
	assign wb.data.x1 = x0_s2;
	assign wb.data.x2 = x1_s2;
	assign wb.data.y0 = y_new;
	assign wb.data.y1 = y0_s2;
	assign wb.data.y2 = y1_s2;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				s1_v_q <= 1'b1;
			end else if (s1_adv) begin
				s1_v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_v_q <= 1'b1;
			end else if (s2_adv) begin
				s2_v_q <= 1'b0;
			end
			if (s2_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (load) begin
			led_s1      <= ld_led;
			in_range_s1 <= ld_in_range;
			sample_s1   <= ld_sample;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			led_s2      <= led_s1;
			in_range_s2 <= in_range_s1;
			sample_s2   <= sample_s1;
			x0_s2       <= rd_hist.x0;
			x1_s2       <= rd_hist.x1;
			y0_s2       <= rd_hist.y0;
			y1_s2       <= rd_hist.y1;
			pb0_s2      <= 32'(mul_b0);
			pb1_s2      <= 32'(mul_b1);
			pb2_s2      <= 32'(mul_b2);
			pb3_s2      <= 32'(mul_b3);
			pa1_s2      <= mul_a1[31:0];
			pa2_s2      <= mul_a2[31:0];
			pa3_s2      <= mul_a3[31:0];
		end
	end

	// Output register; an LED outside the strip gives a dark, zero word.
	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_led_q <= led_s2;
			if (in_range_s2) begin
				out_bright_q <= lit ? BRIGHT_ON : BRIGHT_OFF;
				out_level_q  <= y_new;
			end else begin
				out_bright_q <= BRIGHT_OFF;
				out_level_q  <= '0;
			end
		end
	end

	assign out_valid  = out_v_q;
	assign out_led    = out_led_q;
	assign out_bright = out_bright_q;
	assign out_level  = out_level_q;

endmodule

`default_nettype wire

[rtl/filtered_noise_led_twinkle.sv]
// ----------------------------------------------------------------------------
// filtered_noise_led_twinkle: IIR-filtered noise LED twinkle
// Advances one LED's third-order noise filter per input word and returns
// its new level and on/off brightness.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word passes through stage 1, stage 2 and the output register.
// Throughput: one word per cycle for different LEDs while the output is not stalled;
// a word for an LED still in stage 1 or stage 2 waits until its history is written back.
// Reset: registers return to their defaults and the history RAM is cleared by a sweep
// over all LED_TOTAL (512) entries, during which no input word is taken.
`default_nettype none

module filtered_noise_led_twinkle
	import fnlt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input stream. tdata: [8:0] led_index, rest zero.
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// Result stream. tdata: [8:0] led_number, [16:9] brightness,
	// [48:17] filtered_level, rest zero.
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
	// Configuration write channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	coef_t      coef;
	wb_t        wb;
	pipe_stat_t stat;
	hist_t      rd_hist;

	logic [IDX_W-1:0]    led;
	logic                in_range;
	logic                hazard;
	logic                accept;
	logic [15:0]         sample;

	logic                clr_busy_q;
	logic [LED_AW-1:0]   clr_addr_q;

	logic                ram_wr_en;
	logic [LED_AW-1:0]   ram_wr_addr;
	hist_t               ram_wr_data;

	logic [IDX_W-1:0]    out_led;
	logic [BRIGHT_W-1:0] out_bright;
	logic [LEVEL_W-1:0]  out_level;

	// Input decode and same-LED interlock.
	assign led      = s_axis_tdata[IDX_W-1:0];
	assign in_range = int'(led) < LED_TOTAL;
	assign hazard   = (stat.s1_v && (stat.s1_led == led)) ||
	                  (stat.s2_v && (stat.s2_led == led));

	assign s_axis_tready = !clr_busy_q && stat.s1_free && !hazard;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// History clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LED_AW'(LED_TOTAL - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// RAM write port is shared by the clearing sweep and the filter write-back.
	assign ram_wr_en   = clr_busy_q || wb.en;
	assign ram_wr_addr = clr_busy_q ? clr_addr_q : wb.addr;
	assign ram_wr_data = clr_busy_q ? '0 : wb.data;

	fnlt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	fnlt_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept && in_range),
		.sample (sample)
	);

	fnlt_ram #(
		.WIDTH (HIST_W),
		.DEPTH (LED_TOTAL)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (accept),
		.rd_addr (LED_AW'(led)),
		.rd_data (rd_hist)
	);

	fnlt_filter u_filter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.ld_led      (led),
		.ld_in_range (in_range),
		.ld_sample   (sample),
		.rd_hist     (rd_hist),
		.coef        (coef),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_led     (out_led),
		.out_bright  (out_bright),
		.out_level   (out_level),
		.wb          (wb),
		.stat        (stat)
	);

	// Result word packing.
	assign m_axis_tdata = {
		{(OUT_TDATA_W - IDX_W - BRIGHT_W - LEVEL_W){1'b0}},
		out_level,
		out_bright,
		out_led
	};

endmodule

`default_nettype wire

[rtl/fnlt_checker.sv]
// ----------------------------------------------------------------------------
// fnlt_checker: port-level checks for the LED twinkle block
// Watches the result stream of the top level; attached by a bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module fnlt_checker
	import fnlt_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [CFG_IDX_W-1:0]   cfg_index,
	input wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// Brightness is either fully on or fully off.
	a_bright_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[16:9] == BRIGHT_ON) ||
		                  (m_axis_tdata[16:9] == BRIGHT_OFF))
		else $error("brightness is neither on nor off");

	// The filter level is a 32-bit value divided by 4096, so its upper
	// thirteen bits are all equal.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[48:36] == 13'h0000) ||
		                  (m_axis_tdata[48:36] == 13'h1fff))
		else $error("filter level out of the divided range");

	// Pad bits of the result word stay zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:49] == '0)
		else $error("result pad bits not zero");

endmodule

bind filtered_noise_led_twinkle fnlt_checker u_fnlt_checker (.*);

`default_nettype wire

[tb/tb_filtered_noise_led_twinkle.sv]
// ----------------------------------------------------------------------------
// tb_filtered_noise_led_twinkle: self-checking bench for the LED twinkle filter
// Drives LED index words through the input stream, keeps a cycle-free model
// of the noise generator and the per-LED third-order filters, and compares
// every result word field by field. A short directed table comes first,
// then random phases under several coefficient sets and flow-control paces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_filtered_noise_led_twinkle;
	import fnlt_pkg::*;

	localparam int HALF_PERIOD   = 1;
	localparam int RESET_CYCLES  = 8;
	localparam int DRAIN_CYCLES  = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_WORDS   = 92;
	localparam int DIRECTED_ROWS = 33;
	localparam int PRINT_LIMIT   = 20;
	localparam int LIMIT_NS      = 400000;

	// Register widths and reset contents, indexed by register code.
	localparam int REG_W [8] = '{12, 12, 12, 12, 15, 15, 15, 17};
	localparam logic [CFG_DATA_W-1:0] RESET_BITS [8] = '{
		17'(B0_RST), 17'(B1_RST), 17'(B2_RST), 17'(B3_RST),
		17'(A1_RST), 17'(A2_RST), 17'(A3_RST), 17'(THR_RST)
	};

	typedef enum int {
		COEF_RESET,
		COEF_RANDOM,
		COEF_MAX,
		COEF_MIN
	} coef_style_t;

	typedef struct packed {
		logic [IDX_W-1:0]    led;
		logic [BRIGHT_W-1:0] bright;
		logic [LEVEL_W-1:0]  level;
	} led_result_t;

	// One line of the directed table: a register write or an LED word.
	typedef struct {
		logic                  is_cfg;
		cfg_reg_t              sel;
		logic [CFG_DATA_W-1:0] value;
		logic [IDX_W-1:0]      led;
		logic                  typed;
		logic [BRIGHT_W-1:0]   bright;
		logic [LEVEL_W-1:0]    level;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Model state: registers as written, noise generator, per-LED histories.
	logic [CFG_DATA_W-1:0] reg_bits [8];
	logic [31:0]           noise_state;
	logic [15:0]           sample_hist [LED_TOTAL][3];
	logic [31:0]           level_hist [LED_TOTAL][3];

	led_result_t levels_due [$];
	stim_row_t   directed_rows [DIRECTED_ROWS];

	int mismatches    = 0;
	int results_seen  = 0;
	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int hold_requests = 0;
	int holds_taken   = 0;
	int hold_left     = 0;

	filtered_noise_led_twinkle dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Register contents sign-extended from the register's own width.
	function automatic logic [31:0] coef32(input cfg_reg_t sel);
		logic [31:0] mask;
		logic [31:0] v;
		mask = (32'd1 << REG_W[sel]) - 32'd1;
		v = {15'd0, reg_bits[sel]} & mask;
		if (v[REG_W[sel]-1]) v = v | ~mask;
		return v;
	endfunction

	task automatic reset_model();
		for (int i = 0; i < 8; i++) reg_bits[i] = RESET_BITS[i];
		noise_state = '0;
		for (int i = 0; i < LED_TOTAL; i++) begin
			for (int k = 0; k < 3; k++) begin
				sample_hist[i][k] = '0;
				level_hist[i][k] = '0;
			end
		end
	endtask

	// Advances the shared noise generator and one LED's filter by a frame.
	function automatic led_result_t advance_filter(input logic [IDX_W-1:0] led);
		led_result_t r;
		logic [31:0] s;
		logic [31:0] acc;
		int level;
		r.led = led;
		r.bright = BRIGHT_OFF;
		r.level = '0;
		if (led >= LED_TOTAL) return r;
		noise_state = noise_state * LCG_MUL + LCG_ADD;
		s = {16'd0, noise_state[31:16]};
		acc = coef32(REG_B0) * s
			+ coef32(REG_B1) * {16'd0, sample_hist[led][0]}
			+ coef32(REG_B2) * {16'd0, sample_hist[led][1]}
			+ coef32(REG_B3) * {16'd0, sample_hist[led][2]};
		acc = acc - coef32(REG_A1) * level_hist[led][0]
			- coef32(REG_A2) * level_hist[led][1]
			- coef32(REG_A3) * level_hist[led][2];
		// Signed division truncates toward zero.
		level = $signed(acc) / (1 << DIV_SHIFT);
		sample_hist[led][2] = sample_hist[led][1];
		sample_hist[led][1] = sample_hist[led][0];
		sample_hist[led][0] = s[15:0];
		level_hist[led][2] = level_hist[led][1];
		level_hist[led][1] = level_hist[led][0];
		level_hist[led][0] = level;
		r.bright = (level < $signed(coef32(REG_THR))) ? BRIGHT_ON : BRIGHT_OFF;
		r.level = level;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input cfg_reg_t sel,
		input logic [CFG_DATA_W-1:0] value);
		stim_row_t r;
		r = '{1'b1, sel, value, '0, 1'b0, '0, '0};
		return r;
	endfunction

	function automatic stim_row_t led_row(input logic [IDX_W-1:0] led);
		stim_row_t r;
		r = '{1'b0, REG_B0, '0, led, 1'b0, '0, '0};
		return r;
	endfunction

	function automatic stim_row_t led_known(input logic [IDX_W-1:0] led,
		input logic [BRIGHT_W-1:0] bright, input logic [LEVEL_W-1:0] level);
		stim_row_t r;
		r = '{1'b0, REG_B0, '0, led, 1'b1, bright, level};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
		mismatches++;
	endtask

	// Offers one LED word, with random idle cycles ahead of it, and books
	// its expected result once the block takes it.
	task automatic send_led(input logic [IDX_W-1:0] led, input logic typed,
		input logic [BRIGHT_W-1:0] want_bright, input logic [LEVEL_W-1:0] want_level);
		led_result_t due;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W-IDX_W){1'b0}}, led};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		due = advance_filter(led);
		if (typed) begin
			due.bright = want_bright;
			due.level = want_level;
		end
		levels_due.push_back(due);
	endtask

	// Stops offering words and waits until every result is back.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (levels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_bits[sel] = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One random phase: program a coefficient set, then stream words that
	// mostly revisit a small pool of LEDs so their histories build up.
	task automatic run_phase(input coef_style_t style, input int tx_pct, input int rx_pct,
		input bit squeeze);
		logic [CFG_DATA_W-1:0] value;
		logic [IDX_W-1:0]      pool [6];
		logic [IDX_W-1:0]      led;
		int                    pick;
		for (int i = 0; i < 8; i++) begin
			case (style)
				COEF_RESET: value = RESET_BITS[i];
				COEF_MAX: value = CFG_DATA_W'((1 << (REG_W[i] - 1)) - 1);
				COEF_MIN: value = CFG_DATA_W'(1 << (REG_W[i] - 1));
				default: value = CFG_DATA_W'($urandom);
			endcase
			write_reg(cfg_reg_t'(i), value);
		end
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		for (int k = 0; k < 6; k++) pool[k] = IDX_W'($urandom_range(LED_TOTAL - 1));
		led = pool[0];
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (squeeze && n == PHASE_WORDS / 3) hold_requests++;
			pick = $urandom_range(99);
			// Between the pool and the full range, the last LED is repeated.
			if (pick < 60) led = pool[$urandom_range(5)];
			else if (pick >= 75) led = IDX_W'($urandom_range(LED_TOTAL - 1));
			send_led(led, 1'b0, BRIGHT_OFF, '0);
		end
	endtask

	// Result side: random stalls, plus long hold-offs on request.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_taken != hold_requests) begin
			m_axis_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_taken <= holds_taken + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		led_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (levels_due.size() == 0) begin
				report_mismatch("unexpected word", m_axis_tdata[31:0], '0);
			end else begin
				want = levels_due.pop_front();
				if (m_axis_tdata[IDX_W-1:0] != want.led)
					report_mismatch("led_number", m_axis_tdata[IDX_W-1:0], want.led);
				if (m_axis_tdata[IDX_W +: BRIGHT_W] != want.bright)
					report_mismatch("brightness", m_axis_tdata[IDX_W +: BRIGHT_W], want.bright);
				if (m_axis_tdata[IDX_W+BRIGHT_W +: LEVEL_W] != want.level)
					report_mismatch("filtered_level", m_axis_tdata[IDX_W+BRIGHT_W +: LEVEL_W],
						want.level);
			end
			results_seen++;
		end
	end

	initial begin
		stim_row_t row;
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: first frame after reset, index extremes, repeated LEDs,
		// zeroed filters against thresholds, truncated wide writes, extremes.
		directed_rows = '{
			led_known(0, BRIGHT_OFF, 32'd1), led_row(511), led_row(0), led_row(0),
			led_row(0), led_row(256), led_row(255), led_row(341), led_row(170),
			led_row(511),
			cfg_row(REG_B0, 0), cfg_row(REG_B1, 0), cfg_row(REG_B2, 0), cfg_row(REG_B3, 0),
			cfg_row(REG_A1, 0), cfg_row(REG_A2, 0), cfg_row(REG_A3, 0), cfg_row(REG_THR, 1),
			led_known(3, BRIGHT_ON, 32'd0), led_known(511, BRIGHT_ON, 32'd0),
			cfg_row(REG_THR, 0), led_known(7, BRIGHT_OFF, 32'd0),
			cfg_row(REG_B0, 17'h1F801), cfg_row(REG_THR, 17'h0FFFF),
			led_row(9), led_row(9),
			cfg_row(REG_A1, 17'h14000), cfg_row(REG_THR, 17'h10000),
			led_row(9), led_row(9), led_row(9), led_row(300), led_row(1)
		};
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = directed_rows[i];
			if (row.is_cfg) write_reg(row.sel, row.value);
			else send_led(row.led, row.typed, row.bright, row.level);
		end

		// Random part under several coefficient sets and paces.
		run_phase(COEF_RESET, 0, 0, 1'b0);
		run_phase(COEF_RANDOM, 52, 0, 1'b0);
		run_phase(COEF_MAX, 0, 52, 1'b0);
		run_phase(COEF_MIN, 7, 7, 1'b0);
		run_phase(COEF_RANDOM, 0, 0, 1'b1);
		run_phase(COEF_RANDOM, 0, 52, 1'b1);

		settle();
		if (mismatches == 0) begin
			$display("tb_filtered_noise_led_twinkle: done, clean");
		end else begin
			$display("tb_filtered_noise_led_twinkle: done, errors");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#LIMIT_NS;
		$display("tb_filtered_noise_led_twinkle: done, errors");
		$finish;
	end

endmodule

[filtered_noise_led_twinkle.f]
rtl/fnlt_pkg.sv
rtl/fnlt_ram.sv
rtl/fnlt_cfg_regs.sv
rtl/fnlt_lcg.sv
rtl/fnlt_filter.sv
rtl/filtered_noise_led_twinkle.sv
rtl/fnlt_checker.sv
tb/tb_filtered_noise_led_twinkle.sv
